// ===== rtl/pairing_code_window_guard_core_defines.svh =====
// assertion helpers shared by the window guard rtl
`ifndef PAIRING_CODE_WINDOW_GUARD_CORE_DEFINES_SVH
`define PAIRING_CODE_WINDOW_GUARD_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk and quiet in reset
`define PCWG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and quiet in reset
`define PCWG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcwg_pkg.sv =====
package pcwg_pkg;

  // code shape
  localparam int CODE_DIGITS = 6;
  localparam int DIGITS_W    = 4 * CODE_DIGITS;
  localparam int VALUE_W     = 20;
  localparam int RECIP_W     = 21;
  localparam int PIPE_STAGES = 6;
  localparam int ADDR_W      = 4;

  // code space and rejection bound for the random word
  localparam logic [VALUE_W-1:0] CODE_MODULUS = 20'd1000000;
  localparam logic [31:0]        WORD_CEILING = 32'd4294000000;

  // floor(2^40 / 1000000): quotient estimate is low by at most one
  localparam int                 SPACE_SHIFT = 40;
  localparam logic [RECIP_W-1:0] SPACE_RECIP = 21'd1099511;

  // ceil(2^24 / 10): exact quotient for 20-bit values
  localparam int                 TEN_SHIFT = 24;
  localparam logic [RECIP_W-1:0] TEN_RECIP = 21'd1677722;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // register reset values
  localparam logic [15:0] WINDOW_SECONDS_RST   = 16'd300;
  localparam logic [7:0]  MAX_ATTEMPTS_RST     = 8'd5;
  localparam logic [19:0] TICKS_PER_SECOND_RST = 20'd1000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_CLAIM  = 2'd3
  } pcwg_cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_OPEN = 3'd1,
    ST_INVALID  = 3'd2,
    ST_LOCKED   = 3'd3,
    ST_RETRY    = 3'd4
  } pcwg_status_t;

  typedef enum logic [1:0] {
    REG_WINDOW_SECONDS   = 2'd0,
    REG_MAX_ATTEMPTS     = 2'd1,
    REG_TICKS_PER_SECOND = 2'd2
  } pcwg_reg_t;

  typedef struct packed {
    logic [15:0] window_seconds;
    logic [7:0]  max_attempts;
    logic [19:0] ticks_per_second;
  } pcwg_cfg_t;

  // per-beat control that rides alongside the arithmetic
  typedef struct packed {
    pcwg_cmd_t   cmd;
    logic [7:0]  code_length;
    logic        biased;
  } pcwg_ctl_t;

  typedef struct packed {
    pcwg_status_t        status;
    logic                window_active;
    logic [7:0]          failures;
    logic [15:0]         secs_to_go;
    logic [VALUE_W-1:0]  issued_code;
  } pcwg_result_t;

endpackage

// ===== rtl/pcwg_mod_unit.sv =====
module pcwg_mod_unit
  import pcwg_pkg::*;
(
  input  logic                clk,
  input  logic [2:0]          adv,
  input  logic [31:0]         word,
  output logic [VALUE_W-1:0]  value
);

  localparam int PROD_W = 32 + RECIP_W;
  localparam int QUOT_W = PROD_W - SPACE_SHIFT;
  localparam int REM_W  = VALUE_W + 1;

  logic [31:0]        word_s1;
  logic [PROD_W-1:0]  prod_s1;
  logic [REM_W-1:0]   rem_s2;
  logic [QUOT_W-1:0]  quot_est;
  logic [32:0]        quot_scaled;
  logic [32:0]        rem_wide;

  // stage 1: quotient estimate by reciprocal multiply
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      word_s1 <= word;
      prod_s1 <= {{RECIP_W{1'b0}}, word} * {{32{1'b0}}, SPACE_RECIP};
    end
  end

  // stage 2: remainder, below twice the code space
  always_comb begin
    quot_est    = prod_s1[PROD_W-1:SPACE_SHIFT];
    quot_scaled = {{(33-QUOT_W){1'b0}}, quot_est} * {13'd0, CODE_MODULUS};
    rem_wide    = {1'b0, word_s1} - quot_scaled;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rem_s2 <= rem_wide[REM_W-1:0];
    end
  end

  // stage 3: single correction step
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (rem_s2 >= {1'b0, CODE_MODULUS}) begin
        value <= VALUE_W'(rem_s2 - {1'b0, CODE_MODULUS});
      end else begin
        value <= rem_s2[VALUE_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/pcwg_digit_lane.sv =====
module pcwg_digit_lane
  import pcwg_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic [PIPE_STAGES-1:0] adv,
  input  logic [7:0]          code_char,
  input  logic [VALUE_W-1:0]  value,
  input  logic [3:0]          stored_nibble,
  output logic [3:0]          digit,
  output logic                match
);

  // this lane owns the digit of weight 10^(5-LANE), i.e. character LANE
  localparam int unsigned DIV = 10 ** (CODE_DIGITS - 1 - LANE);
  localparam int SHIFT = VALUE_W + $clog2(DIV);
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int PROD_W = VALUE_W + RECIP_W;

  logic              ok_p  [PIPE_STAGES];
  logic [3:0]        val_p [PIPE_STAGES];
  logic [PROD_W-1:0] prod_a;
  logic [VALUE_W-1:0] quot_s5;
  logic [PROD_W-1:0] prod_b;
  logic [VALUE_W-1:0] quot_a;
  logic [VALUE_W-1:0] quot_ten;
  logic [VALUE_W-1:0] rem_ten;

  // character shape check, carried down to the merge stage
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ok_p[0]  <= (code_char >= CHAR_ZERO) && (code_char <= CHAR_NINE);
      val_p[0] <= 4'(code_char - CHAR_ZERO);
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (adv[k]) begin
        ok_p[k]  <= ok_p[k-1];
        val_p[k] <= val_p[k-1];
      end
    end
  end

  // stage 4: scale down to this digit's weight
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      prod_a <= {{RECIP_W{1'b0}}, value} * {{VALUE_W{1'b0}}, RECIP};
    end
  end

  // stage 5: divide by ten
  assign quot_a = VALUE_W'(prod_a >> SHIFT);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      quot_s5 <= quot_a;
      prod_b  <= {{RECIP_W{1'b0}}, quot_a} * {{VALUE_W{1'b0}}, TEN_RECIP};
    end
  end

  // stage 6: remainder by ten is the digit
  always_comb begin
    quot_ten = VALUE_W'(prod_b >> TEN_SHIFT);
    rem_ten  = quot_s5 - ((quot_ten << 3) + (quot_ten << 1));
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      digit <= rem_ten[3:0];
    end
  end

  // compare against the stored digit
  assign match = ok_p[PIPE_STAGES-1] && (val_p[PIPE_STAGES-1] == stored_nibble);

endmodule

// ===== rtl/pcwg_ctrl.sv =====
`include "pairing_code_window_guard_core_defines.svh"

module pcwg_ctrl
  import pcwg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  pcwg_ctl_t              ctl,
  input  logic [VALUE_W-1:0]     code_value,
  input  logic [DIGITS_W-1:0]    new_digits,
  input  logic [CODE_DIGITS-1:0] lane_match,
  input  pcwg_cfg_t              cfg,
  output logic [DIGITS_W-1:0]    stored_digits,
  output pcwg_result_t           res
);

  logic                window_open;
  logic [15:0]         seconds_left;
  logic [19:0]         sub_ticks_left;
  logic [7:0]          failed_count;

  logic                window_open_next;
  logic [DIGITS_W-1:0] stored_digits_next;
  logic [15:0]         seconds_left_next;
  logic [19:0]         sub_ticks_left_next;
  logic [7:0]          failed_count_next;
  pcwg_status_t        status_next;
  logic [VALUE_W-1:0]  issued_next;
  logic [15:0]         remaining_next;

  logic                do_close;
  logic [19:0]         tps_m1;
  logic                matched;
  logic [7:0]          fail_inc;

  // merge lane results and step the window state
  always_comb begin
    window_open_next    = window_open;
    stored_digits_next  = stored_digits;
    seconds_left_next   = seconds_left;
    sub_ticks_left_next = sub_ticks_left;
    failed_count_next   = failed_count;
    status_next         = ST_OK;
    issued_next         = '0;
    do_close            = 1'b0;
    tps_m1   = (cfg.ticks_per_second == '0) ? '0 : cfg.ticks_per_second - 20'd1;
    matched  = (ctl.code_length == 8'(CODE_DIGITS)) && (&lane_match);
    fail_inc = failed_count + 8'd1;

    case (ctl.cmd)
      CMD_TICK: begin
        if (window_open) begin
          if (sub_ticks_left == '0) begin
            if (seconds_left == '0) begin
              do_close = 1'b1;
            end else begin
              seconds_left_next   = seconds_left - 16'd1;
              sub_ticks_left_next = tps_m1;
            end
          end else begin
            sub_ticks_left_next = sub_ticks_left - 20'd1;
          end
          if ((seconds_left_next == '0) && (sub_ticks_left_next == '0)) begin
            do_close = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (ctl.biased) begin
          status_next = ST_RETRY;
        end else begin
          issued_next         = code_value;
          window_open_next    = (cfg.window_seconds != '0);
          stored_digits_next  = (cfg.window_seconds != '0) ? new_digits : '0;
          seconds_left_next   = cfg.window_seconds;
          sub_ticks_left_next = '0;
          failed_count_next   = '0;
        end
      end
      CMD_CANCEL: begin
        do_close = 1'b1;
      end
      CMD_CLAIM: begin
        if (!window_open) begin
          status_next = ST_NOT_OPEN;
        end else if (matched) begin
          do_close = 1'b1;
        end else if (fail_inc >= cfg.max_attempts) begin
          do_close    = 1'b1;
          status_next = ST_LOCKED;
        end else begin
          failed_count_next = fail_inc;
          status_next       = ST_INVALID;
        end
      end
      default: begin
        do_close = 1'b0;
      end
    endcase

    if (do_close) begin
      window_open_next    = 1'b0;
      stored_digits_next  = '0;
      seconds_left_next   = '0;
      sub_ticks_left_next = '0;
      failed_count_next   = '0;
    end

    remaining_next = window_open_next ?
                     seconds_left_next + {15'd0, (sub_ticks_left_next != '0)} : '0;
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_open    <= 1'b0;
      stored_digits  <= '0;
      seconds_left   <= '0;
      sub_ticks_left <= '0;
      failed_count   <= '0;
    end else if (fire) begin
      window_open    <= window_open_next;
      stored_digits  <= stored_digits_next;
      seconds_left   <= seconds_left_next;
      sub_ticks_left <= sub_ticks_left_next;
      failed_count   <= failed_count_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (fire) begin
      res.status        <= status_next;
      res.window_active <= window_open_next;
      res.failures      <= failed_count_next;
      res.secs_to_go    <= remaining_next;
      res.issued_code   <= issued_next;
    end
  end

  `PCWG_ASSERT_IMPLY(a_closed_is_clear, !window_open, (stored_digits == '0) && (seconds_left == '0) && (sub_ticks_left == '0) && (failed_count == '0), "closed window still holds state")
  `PCWG_ASSERT_IMPLY(a_open_has_time, window_open, (seconds_left != '0) || (sub_ticks_left != '0), "open window with no time left")
  `PCWG_ASSERT_NEXT(a_state_needs_beat, !fire, $stable(window_open) && $stable(stored_digits) && $stable(failed_count), "window state moved without a beat")

endmodule

// ===== rtl/pairing_code_window_guard_core.sv =====
// pairing code window guard
// items come in on cmd/random_word/code_length/code_char_* under item_valid and
// item_stall; one result beat (status, window_active, failures, secs_to_go,
// issued_code) goes out under result_valid and result_stall for every item.
// the block is a seven-register pipeline: three stages reduce the random word
// to a code value, three stages of six parallel digit lanes split it into
// decimal digits and check the claimed characters, and a final merge stage
// steps the window state and loads the result register.
// throughput: one item per cycle while result_stall is low; the merge stage
// reads and writes the window state in the same cycle, so back-to-back items
// see each other's effect.
// when result_stall is high the result is held; earlier stages keep filling
// empty slots, and item_stall rises only once every stage holds an item.
// reset (rst, synchronous) empties the pipeline, closes the window, clears
// the stored code and counters and restores the three registers to their
// defaults (300 s window, 5 attempts, 1000 ticks per second).
// registers sit on the apb port at byte offsets 0, 4 and 8.
`include "pairing_code_window_guard_core_defines.svh"

module pairing_code_window_guard_core
  import pcwg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         cmd,
  input  logic [31:0]        random_word,
  input  logic [7:0]         code_length,
  input  logic [7:0]         code_char_0,
  input  logic [7:0]         code_char_1,
  input  logic [7:0]         code_char_2,
  input  logic [7:0]         code_char_3,
  input  logic [7:0]         code_char_4,
  input  logic [7:0]         code_char_5,

  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         status,
  output logic               window_active,
  output logic [7:0]         failures,
  output logic [15:0]        secs_to_go,
  output logic [19:0]        issued_code
);

  pcwg_cfg_t                cfg;
  logic [PIPE_STAGES-1:0]   vld;
  logic [PIPE_STAGES-1:0]   adv;
  logic                     adv_out;
  logic                     fire;
  pcwg_ctl_t                ctl_p [PIPE_STAGES];
  logic [VALUE_W-1:0]       value_s3;
  logic [VALUE_W-1:0]       value_d [3];
  logic [7:0]               code_chars [CODE_DIGITS];
  logic [3:0]               lane_digit [CODE_DIGITS];
  logic [CODE_DIGITS-1:0]   lane_match;
  logic [DIGITS_W-1:0]      new_digits;
  logic [DIGITS_W-1:0]      stored_digits;
  pcwg_result_t             res;
  logic                     cfg_write;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_seconds   <= WINDOW_SECONDS_RST;
      cfg.max_attempts     <= MAX_ATTEMPTS_RST;
      cfg.ticks_per_second <= TICKS_PER_SECOND_RST;
    end else if (cfg_write) begin
      case (pcwg_reg_t'(paddr[3:2]))
        REG_WINDOW_SECONDS:   cfg.window_seconds   <= pwdata[15:0];
        REG_MAX_ATTEMPTS:     cfg.max_attempts     <= pwdata[7:0];
        REG_TICKS_PER_SECOND: cfg.ticks_per_second <= pwdata[19:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (pcwg_reg_t'(paddr[3:2]))
      REG_WINDOW_SECONDS:   prdata = {16'd0, cfg.window_seconds};
      REG_MAX_ATTEMPTS:     prdata = {24'd0, cfg.max_attempts};
      REG_TICKS_PER_SECOND: prdata = {12'd0, cfg.ticks_per_second};
      default:              prdata = '0;
    endcase
  end

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    adv_out = !result_valid || !result_stall;
    adv[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || adv_out;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign item_stall = !adv[0];
  assign fire       = adv_out && vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (adv_out) begin
        result_valid <= vld[PIPE_STAGES-1];
      end
    end
  end

  // command, length and the bias flag ride along the pipeline
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ctl_p[0].cmd         <= pcwg_cmd_t'(cmd);
      ctl_p[0].code_length <= code_length;
      ctl_p[0].biased      <= (random_word >= WORD_CEILING);
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (adv[k]) begin
        ctl_p[k] <= ctl_p[k-1];
      end
    end
  end

  // code value delayed to line up with the digit lanes
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      value_d[0] <= value_s3;
    end
    if (adv[4]) begin
      value_d[1] <= value_d[0];
    end
    if (adv[5]) begin
      value_d[2] <= value_d[1];
    end
  end

  pcwg_mod_unit u_mod (
    .clk   (clk),
    .adv   (adv[2:0]),
    .word  (random_word),
    .value (value_s3)
  );

  assign code_chars[0] = code_char_0;
  assign code_chars[1] = code_char_1;
  assign code_chars[2] = code_char_2;
  assign code_chars[3] = code_char_3;
  assign code_chars[4] = code_char_4;
  assign code_chars[5] = code_char_5;

  // one lane per code character; lane i owns the i-th digit from the top
  for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_lane
    pcwg_digit_lane #(
      .LANE (i)
    ) u_lane (
      .clk           (clk),
      .adv           (adv),
      .code_char     (code_chars[i]),
      .value         (value_s3),
      .stored_nibble (stored_digits[4*(CODE_DIGITS-1-i) +: 4]),
      .digit         (lane_digit[i]),
      .match         (lane_match[i])
    );
    assign new_digits[4*(CODE_DIGITS-1-i) +: 4] = lane_digit[i];
  end

  pcwg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .ctl           (ctl_p[PIPE_STAGES-1]),
    .code_value    (value_d[2]),
    .new_digits    (new_digits),
    .lane_match    (lane_match),
    .cfg           (cfg),
    .stored_digits (stored_digits),
    .res           (res)
  );

  // result beat fields
  assign status        = res.status;
  assign window_active = res.window_active;
  assign failures      = res.failures;
  assign secs_to_go    = res.secs_to_go;
  assign issued_code   = res.issued_code;

  `PCWG_ASSERT_IMPLY(a_closed_result, result_valid && !window_active, (secs_to_go == '0) && (failures == '0), "closed window reports time or failures")
  `PCWG_ASSERT_IMPLY(a_retry_no_code, result_valid && (status == ST_RETRY), issued_code == '0, "rejected word issued a code")

endmodule
